### rtl/sscd_pkg.sv
package sscd_pkg;

  // run states, also the status field of a result
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WAIT  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_DONE  = 3'd3;
  localparam logic [2:0] ST_ABORT = 3'd4;

  // display modes
  localparam logic [1:0] MODE_TRIPLE = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_BLINK  = 2'd2;

  // request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // register indexes
  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
  localparam logic [1:0] REG_MODE  = 2'd2;

  localparam logic [9:0] MAX_VALUE    = 10'd999;
  localparam logic [3:0] SLOTS_NORMAL = 4'd4;
  localparam logic [3:0] SLOTS_BLINK  = 4'd10;
  localparam logic [6:0] SEG_ZERO     = 7'h3F;

  localparam int OUT_W = 40;

  // state snapshot handed from the control stage to the display stage
  typedef struct packed {
    logic [9:0] count;
    logic [3:0] sub;
    logic [2:0] state;
    logic [1:0] mode;
  } sscd_snap_t;

  // digit to segments, bit0 a .. bit6 g
  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

### rtl/sscd_ctrl.sv
module sscd_ctrl
  import sscd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_acc,
  input  logic        req_type,
  input  logic        button,
  input  logic [9:0]  start_value,
  input  logic [9:0]  end_value,
  input  logic [1:0]  display_mode,
  input  logic        adv,
  output logic        in_ready,
  output logic        s1_valid,
  output sscd_snap_t  snap
);

  logic [9:0]  count_r, count_nxt;
  logic [3:0]  sub_r, sub_nxt;
  logic [2:0]  state_r, state_nxt;
  logic        s1_valid_r, s1_valid_nxt;
  sscd_snap_t  snap_r;

  logic [9:0]  s_clamp, e_clamp;
  logic [10:0] e_plus1;
  logic        blink;
  logic        run_go;
  logic [2:0]  begin_state;
  logic [3:0]  sub_inc, limit;

  assign in_ready = !s1_valid_r || adv;
  assign s1_valid = s1_valid_r;
  assign snap     = snap_r;

  // run bounds and slot limits
  assign s_clamp     = (start_value > MAX_VALUE) ? MAX_VALUE : start_value;
  assign e_clamp     = (end_value > MAX_VALUE) ? MAX_VALUE : end_value;
  assign e_plus1     = {1'b0, e_clamp} + 11'd1;
  assign blink       = (display_mode == MODE_BLINK);
  assign run_go      = blink ? (s_clamp > e_clamp) : (s_clamp >= e_clamp);
  assign begin_state = run_go ? ST_RUN : ST_DONE;
  assign sub_inc     = sub_r + 4'd1;
  assign limit       = blink ? SLOTS_BLINK : SLOTS_NORMAL;

  // next run state for one beat
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    sub_nxt   = sub_r;
    if (req_type == REQ_START) begin
      sub_nxt = 4'd0;
      if (button) begin
        count_nxt = 10'd0;
        state_nxt = ST_WAIT;
      end else begin
        count_nxt = s_clamp;
        state_nxt = begin_state;
      end
    end else if (state_r == ST_WAIT) begin
      if (!button) begin
        sub_nxt   = 4'd0;
        count_nxt = s_clamp;
        state_nxt = begin_state;
      end
    end else if (state_r == ST_RUN) begin
      if (button) begin
        state_nxt = ST_ABORT;
      end else if (sub_inc < limit) begin
        sub_nxt = sub_inc;
      end else begin
        sub_nxt = 4'd0;
        if (blink) begin
          if ({1'b0, count_r} <= e_plus1) begin
            count_nxt = 10'd0;
            state_nxt = ST_DONE;
          end else begin
            count_nxt = count_r - 10'd1;
          end
        end else begin
          if (count_r <= e_clamp) begin
            state_nxt = ST_DONE;
          end else begin
            count_nxt = count_r - 10'd1;
          end
        end
      end
    end
  end

  assign s1_valid_nxt = in_acc || (s1_valid_r && !adv);

  // run state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= 10'd0;
      sub_r      <= 4'd0;
      state_r    <= ST_IDLE;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (in_acc) begin
        count_r <= count_nxt;
        sub_r   <= sub_nxt;
        state_r <= state_nxt;
      end
    end
  end

  // snapshot for the display stage
  always_ff @(posedge clk) begin
    if (in_acc) begin
      snap_r.count <= count_nxt;
      snap_r.sub   <= sub_nxt;
      snap_r.state <= state_nxt;
      snap_r.mode  <= display_mode;
    end
  end

endmodule

### rtl/sscd_disp.sv
module sscd_disp
  import sscd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  sscd_snap_t        snap,
  output logic              adv,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  out_data
);

  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  logic [15:0] h_prod;
  logic [3:0]  h_dig, t_dig, o_dig;
  logic [9:0]  rem_w;
  logic [6:0]  rem;
  logic [14:0] t_prod;
  logic [6:0]  o_w;
  logic        blink, active;
  logic [6:0]  sh, st, so;
  logic        fw, lo;
  logic [9:0]  sv;

  assign adv       = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // digit split by reciprocal multiply, exact for 0..999
  assign h_prod = {6'd0, snap.count} * 16'd41;
  assign h_dig  = h_prod[15:12];
  assign rem_w  = snap.count - ({6'd0, h_dig} * 10'd100);
  assign rem    = rem_w[6:0];
  assign t_prod = {8'd0, rem} * 15'd205;
  assign t_dig  = t_prod[14:11];
  assign o_w    = rem - ({3'd0, t_dig} * 7'd10);
  assign o_dig  = o_w[3:0];

  assign blink  = (snap.mode == MODE_BLINK);
  assign active = (snap.state == ST_RUN) || (snap.state == ST_ABORT) ||
                  (snap.state == ST_DONE);

  // display selection
  always_comb begin
    sh = 7'd0;
    st = 7'd0;
    so = 7'd0;
    fw = 1'b0;
    lo = 1'b0;
    sv = 10'd0;
    if (active) begin
      if (blink && snap.state == ST_DONE) begin
        sh = SEG_ZERO;
        st = SEG_ZERO;
        so = SEG_ZERO;
      end else if (blink && !snap.sub[0]) begin
        fw = 1'b1;
        lo = 1'b1;
        sv = snap.count;
      end else if (snap.mode == MODE_SINGLE) begin
        so = seg_of(o_dig);
        sv = snap.count;
      end else begin
        // leading zero blanking
        if (h_dig != 4'd0) sh = seg_of(h_dig);
        if (h_dig != 4'd0 || t_dig != 4'd0) st = seg_of(t_dig);
        so = seg_of(o_dig);
        sv = snap.count;
      end
    end
  end

  assign out_data_nxt = {4'd0, snap.state, sv, lo, fw, so, st, sh};

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

### rtl/seven_segment_countdown_timer.sv
// an accepted beat goes into the control stage snapshot register, then into the result register on out_tdata
// throughput: one beat per cycle while in_tready is high; the run state updates on every accepted beat
// in_tready drops only while both pipeline registers hold a beat and the result is stalled
// reset (rst_n low, synchronous): run state idle, count and slot zero,
// pipeline empty, registers start 120, end 0, mode three digits
module seven_segment_countdown_timer
  import sscd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [0] button
  input  logic [0:0]          in_tuser,   // [0] req_type
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  // [6:0] seg_hundreds, [13:7] seg_tens, [20:14] seg_ones, [21] flash_white,
  // [22] lights_on, [32:23] shown_value, [35:33] status
  output logic [OUT_W-1:0]    out_tdata,
  // configuration
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic [9:0]  start_r;
  logic [9:0]  end_r;
  logic [1:0]  mode_r;
  logic        cfg_wr;
  logic        in_acc;
  logic        adv;
  logic        s1_valid;
  sscd_snap_t  snap;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign in_acc     = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 10'd120;
      end_r   <= 10'd0;
      mode_r  <= MODE_TRIPLE;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_START: start_r <= cfg_pwdata[9:0];
        REG_END:   end_r   <= cfg_pwdata[9:0];
        REG_MODE:  mode_r  <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_paddr[3:2])
      REG_START: cfg_prdata = {22'd0, start_r};
      REG_END:   cfg_prdata = {22'd0, end_r};
      REG_MODE:  cfg_prdata = {30'd0, mode_r};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  sscd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_acc       (in_acc),
    .req_type     (in_tuser[0]),
    .button       (in_tdata[0]),
    .start_value  (start_r),
    .end_value    (end_r),
    .display_mode (mode_r),
    .adv          (adv),
    .in_ready     (in_tready),
    .s1_valid     (s1_valid),
    .snap         (snap)
  );

  sscd_disp u_disp (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .snap      (snap),
    .adv       (adv),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

### rtl/sscd_chk.sv
module sscd_chk
  import sscd_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [OUT_W-1:0]   out_tdata
);

  logic [2:0] status;
  logic       quiet;

  assign status = out_tdata[35:33];
  assign quiet  = (status == ST_IDLE) || (status == ST_WAIT);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // idle and waiting show a dark display with value zero
  a_quiet_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && quiet |-> out_tdata[32:0] == 33'd0)
    else $error("display lit while idle or waiting");

  // flash and lights always go together
  a_flash_lights: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[21] == out_tdata[22])
    else $error("flash and lights disagree");

endmodule

bind seven_segment_countdown_timer sscd_chk u_sscd_chk (.*);

### bench/tb.sv
module tb;
  import sscd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // display mode that the block treats as three digits
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD = 120;
  // digit glyphs 9 down to 0, bit0 a .. bit6 g
  localparam logic [69:0] GLYPHS = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                    7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

  // one displayed frame, laid out as out_tdata from the top bit down
  typedef struct packed {
    logic [3:0] pad;
    logic [2:0] status;
    logic [9:0] shown;
    logic       lights;
    logic       flash;
    logic [6:0] ones;
    logic [6:0] tens;
    logic [6:0] hundreds;
  } timer_view_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;   // [0] button
  logic [0:0]       in_tuser = '0;   // [0] req_type
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // [6:0] seg_hundreds, [13:7] seg_tens, [20:14] seg_ones, [21] flash_white,
  // [22] lights_on, [32:23] shown_value, [35:33] status
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_psel = 1'b0;
  logic             cfg_penable = 1'b0;
  logic             cfg_pwrite = 1'b0;
  logic [3:0]       cfg_paddr = '0;
  logic [31:0]      cfg_pwdata = '0;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;

  // timer shadow: registers and run state
  logic [9:0] start_reg = 10'd120;
  logic [9:0] end_reg = 10'd0;
  logic [1:0] mode_reg = MODE_TRIPLE;
  logic [9:0] count_q = '0;
  logic [3:0] slot_q = '0;
  logic [2:0] run_q = ST_IDLE;

  timer_view_t expected_views[$];
  int unsigned fail_count = 0;
  int unsigned beats_sent = 0;
  int unsigned frames_seen = 0;
  int unsigned cycle_count = 0;
  int          burst_left = 0;
  bit          steady_feed = 1'b0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  logic [7:0]  rx_phase = '0;

  seven_segment_countdown_timer dut (.*);

  always #4 clk = ~clk;

  function automatic logic [6:0] glyph(int d);
    return GLYPHS[d*7 +: 7];
  endfunction

  function automatic int sat999(logic [9:0] v);
    return (v > MAX_VALUE) ? int'(MAX_VALUE) : int'(v);
  endfunction

  task automatic report(string what, int unsigned want, int unsigned got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch at frame %0d, %0s: expected %0h, got %0h",
               frames_seen, what, want, got);
  endtask

  // load the start value and decide whether there is anything to count
  task automatic launch_countdown();
    int s;
    int e;
    s = sat999(start_reg);
    e = sat999(end_reg);
    count_q = s[9:0];
    slot_q = '0;
    if ((mode_reg == MODE_BLINK) ? (s > e) : (s >= e))
      run_q = ST_RUN;
    else
      run_q = ST_DONE;
  endtask

  // advance the shadow by one accepted beat and queue the frame it shows
  task automatic predict_beat(logic req, logic btn);
    timer_view_t view;
    bit blink;
    int e;
    int v;
    int h;
    int t;
    int o;
    e = sat999(end_reg);
    blink = (mode_reg == MODE_BLINK);
    if (req == REQ_START) begin
      if (btn) begin
        count_q = '0;
        slot_q = '0;
        run_q = ST_WAIT;
      end else begin
        launch_countdown();
      end
    end else if (run_q == ST_WAIT) begin
      if (!btn) launch_countdown();
    end else if (run_q == ST_RUN) begin
      if (btn) begin
        run_q = ST_ABORT;
      end else begin
        // one timing slot, a full set of slots moves the count
        slot_q = slot_q + 4'd1;
        if (slot_q >= (blink ? SLOTS_BLINK : SLOTS_NORMAL)) begin
          slot_q = '0;
          if (blink) begin
            if (int'(count_q) <= e + 1) begin
              count_q = '0;
              run_q = ST_DONE;
            end else begin
              count_q = count_q - 10'd1;
            end
          end else if (int'(count_q) <= e) begin
            run_q = ST_DONE;
          end else begin
            count_q = count_q - 10'd1;
          end
        end
      end
    end
    // display of the new state
    v = sat999(count_q);
    h = v / 100;
    t = (v % 100) / 10;
    o = v % 10;
    view = '0;
    if (run_q inside {ST_RUN, ST_ABORT, ST_DONE}) begin
      if (blink && run_q == ST_DONE) begin
        view.hundreds = SEG_ZERO;
        view.tens = SEG_ZERO;
        view.ones = SEG_ZERO;
      end else if (blink && !slot_q[0]) begin
        view.flash = 1'b1;
        view.lights = 1'b1;
        view.shown = v[9:0];
      end else if (mode_reg == MODE_SINGLE) begin
        view.ones = glyph(o);
        view.shown = v[9:0];
      end else begin
        if (h > 0) view.hundreds = glyph(h);
        if (h > 0 || t > 0) view.tens = glyph(t);
        view.ones = glyph(o);
        view.shown = v[9:0];
      end
    end
    view.status = run_q;
    expected_views.push_back(view);
  endtask

  // one input beat, with burst gaps in front of it
  task automatic send_beat(logic req, logic btn);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady_feed || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {7'd0, btn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_beat(req, btn);
    beats_sent++;
  endtask

  // stop feeding and wait until every frame is back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // register write: setup then access
  task automatic write_reg(logic [1:0] idx, logic [9:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {22'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_START: start_reg = value;
      REG_END:   end_reg = value;
      REG_MODE:  mode_reg = value[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // start (sometimes through a held button), then ticks with rare aborts
  // and restarts; a mode change can land part way through
  task automatic run_countdown(int ticks, int switch_at);
    int r;
    bit held;
    held = ($urandom_range(0, 3) == 0);
    if (held) begin
      send_beat(REQ_START, 1'b1);
      repeat ($urandom_range(0, 2)) send_beat(REQ_TICK, 1'b1);
      send_beat($urandom_range(0, 1) ? REQ_TICK : REQ_START, 1'b0);
    end else begin
      send_beat(REQ_START, 1'b0);
    end
    for (int i = 0; i < ticks; i++) begin
      if (i == switch_at) begin
        settle();
        write_reg(REG_MODE, 10'($urandom_range(0, 3)));
      end
      r = $urandom_range(0, 99);
      if (r < 2)
        send_beat(REQ_TICK, 1'b1);
      else if (r < 4)
        send_beat(REQ_START, 1'($urandom_range(0, 1)));
      else
        send_beat(REQ_TICK, 1'b0);
    end
  endtask

  // ticks while idle, start with the button held, release, abort
  task automatic test_idle_and_release();
    send_beat(REQ_TICK, 1'b0);
    send_beat(REQ_TICK, 1'b1);
    send_beat(REQ_START, 1'b1);
    send_beat(REQ_TICK, 1'b1);
    send_beat(REQ_TICK, 1'b0);
    repeat (5) send_beat(REQ_TICK, 1'b0);
    send_beat(REQ_TICK, 1'b1);
    send_beat(REQ_TICK, 1'b0);
    settle();
  endtask

  // saturated registers, unused mode, empty run, leading zero blanking
  task automatic test_register_extremes();
    write_reg(REG_START, 10'd1023);
    write_reg(REG_END, 10'd1000);
    write_reg(REG_MODE, 10'(MODE_UNUSED));
    send_beat(REQ_START, 1'b0);
    repeat (5) send_beat(REQ_TICK, 1'b0);
    settle();
    write_reg(REG_START, 10'd5);
    write_reg(REG_END, 10'd7);
    write_reg(REG_MODE, 10'(MODE_SINGLE));
    send_beat(REQ_START, 1'b0);
    send_beat(REQ_TICK, 1'b0);
    settle();
    write_reg(REG_START, 10'd12);
    write_reg(REG_END, 10'd9);
    write_reg(REG_MODE, 10'(MODE_TRIPLE));
    send_beat(REQ_START, 1'b0);
    repeat (5) send_beat(REQ_TICK, 1'b0);
    settle();
  endtask

  // blink run to 000, empty blink run, mode switch mid run, abort in blink mode
  task automatic test_blink_cycle();
    write_reg(REG_START, 10'd2);
    write_reg(REG_END, 10'd1);
    write_reg(REG_MODE, 10'(MODE_BLINK));
    send_beat(REQ_START, 1'b0);
    repeat (11) send_beat(REQ_TICK, 1'b0);
    settle();
    write_reg(REG_START, 10'd1);
    send_beat(REQ_START, 1'b0);
    settle();
    write_reg(REG_START, 10'd10);
    write_reg(REG_END, 10'd0);
    send_beat(REQ_START, 1'b0);
    repeat (3) send_beat(REQ_TICK, 1'b0);
    settle();
    write_reg(REG_MODE, 10'(MODE_TRIPLE));
    repeat (2) send_beat(REQ_TICK, 1'b0);
    settle();
    write_reg(REG_MODE, 10'(MODE_BLINK));
    send_beat(REQ_TICK, 1'b1);
    send_beat(REQ_TICK, 1'b0);
    settle();
  endtask

  // random settings with short countdowns, mostly well formed
  task automatic test_random_countdowns();
    int r;
    int e;
    int s;
    int ticks;
    int switch_at;
    while (beats_sent < 650) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        r = $urandom_range(0, 7);
        e = (r == 0) ? 0 : (r == 1) ? 1023 : $urandom_range(0, 1023);
        s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                         : e + $urandom_range(0, 3);
        if (s > 1023) s = 1023;
        r = $urandom_range(0, 9);
        write_reg(REG_START, s[9:0]);
        write_reg(REG_END, e[9:0]);
        write_reg(REG_MODE, 10'((r < 3) ? MODE_TRIPLE : (r < 6) ? MODE_SINGLE :
                                (r < 9) ? MODE_BLINK : MODE_UNUSED));
      end
      ticks = $urandom_range(2, 36);
      switch_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, ticks - 1) : -1;
      run_countdown(ticks, switch_at);
    end
    settle();
  endtask

  // receiver holds off for a long stretch while beats keep coming
  task automatic test_output_backpressure();
    steady_feed = 1'b1;
    burst_left = 0;
    hold_reqs++;
    run_countdown(40, -1);
    steady_feed = 1'b0;
    settle();
  endtask

  // receiver: long hold on request, otherwise a rotating stall pattern
  always @(posedge clk) begin
    rx_phase <= rx_phase + 8'd1;
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      case (rx_phase[7:6])
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= 1'($urandom_range(0, 1));
        2'd2: out_tready <= (rx_phase[2:0] != 3'd0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // result check against the oldest expected frame
  always @(posedge clk) begin
    timer_view_t got;
    timer_view_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      frames_seen++;
      if (expected_views.size() == 0) begin
        report("frame with nothing expected", 0, 32'(got.status));
      end else begin
        want = expected_views.pop_front();
        if (got.hundreds != want.hundreds)
          report("seg_hundreds", 32'(want.hundreds), 32'(got.hundreds));
        if (got.tens != want.tens)
          report("seg_tens", 32'(want.tens), 32'(got.tens));
        if (got.ones != want.ones)
          report("seg_ones", 32'(want.ones), 32'(got.ones));
        if (got.flash != want.flash)
          report("flash_white", 32'(want.flash), 32'(got.flash));
        if (got.lights != want.lights)
          report("lights_on", 32'(want.lights), 32'(got.lights));
        if (got.shown != want.shown)
          report("shown_value", 32'(want.shown), 32'(got.shown));
        if (got.status != want.status)
          report("status", 32'(want.status), 32'(got.status));
        if (got.pad != want.pad)
          report("padding", 32'(want.pad), 32'(got.pad));
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int waited;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_and_release();
    test_register_extremes();
    test_blink_cycle();
    test_random_countdowns();
    test_output_backpressure();
    // drain, then a short quiet stretch for stray frames
    in_tvalid <= 1'b0;
    waited = 0;
    while (expected_views.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_views.size() != 0)
      report("frames never delivered", 0, expected_views.size());
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
